// ===== rtl/etl_pkg.sv =====
// Shared types, constants and character classification for the expression token lexer.
// No dependencies; every rtl file imports this package.

package etl_pkg;

    // Offset counter width and token field widths
    localparam int OFFSET_BITS = 16;
    localparam int FIELD_W     = 16;
    localparam int KIND_W      = 4;

    // Lexer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_IDENT = 3'd1;
    localparam logic [2:0] ST_INT   = 3'd2;
    localparam logic [2:0] ST_FRAC  = 3'd3;
    localparam logic [2:0] ST_DOTP  = 3'd4;

    // Token kinds
    localparam logic [KIND_W-1:0] K_PLUS    = 4'd0;
    localparam logic [KIND_W-1:0] K_MINUS   = 4'd1;
    localparam logic [KIND_W-1:0] K_STAR    = 4'd2;
    localparam logic [KIND_W-1:0] K_SLASH   = 4'd3;
    localparam logic [KIND_W-1:0] K_CARET   = 4'd4;
    localparam logic [KIND_W-1:0] K_PERCENT = 4'd5;
    localparam logic [KIND_W-1:0] K_LPAREN  = 4'd6;
    localparam logic [KIND_W-1:0] K_RPAREN  = 4'd7;
    localparam logic [KIND_W-1:0] K_COMMA   = 4'd8;
    localparam logic [KIND_W-1:0] K_DOT     = 4'd9;
    localparam logic [KIND_W-1:0] K_EQUAL   = 4'd10;
    localparam logic [KIND_W-1:0] K_PIPE    = 4'd11;
    localparam logic [KIND_W-1:0] K_NUMBER  = 4'd12;
    localparam logic [KIND_W-1:0] K_IDENT   = 4'd13;
    localparam logic [KIND_W-1:0] K_EOF     = 4'd14;

    // Character codes
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_POINT   = 8'h2E;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;

    // Offset saturation limit
    localparam logic [OFFSET_BITS-1:0] OFS_MAX = {OFFSET_BITS{1'b1}};

    // Token queue depth between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One result token
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic               last;
    } token_t;

    // All tokens caused by one input item: one, or two when two is set
    typedef struct packed {
        logic   two;
        token_t tok0;
        token_t tok1;
    } entry_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
    endfunction

    // Map a single-character token; valid low when the byte is not one
    function automatic logic [KIND_W:0] single_kind(input logic [7:0] c);
        logic [KIND_W:0] r;
        case (c)
            CH_PLUS:    r = {1'b1, K_PLUS};
            CH_MINUS:   r = {1'b1, K_MINUS};
            CH_STAR:    r = {1'b1, K_STAR};
            CH_SLASH:   r = {1'b1, K_SLASH};
            CH_CARET:   r = {1'b1, K_CARET};
            CH_PERCENT: r = {1'b1, K_PERCENT};
            CH_LPAREN:  r = {1'b1, K_LPAREN};
            CH_RPAREN:  r = {1'b1, K_RPAREN};
            CH_COMMA:   r = {1'b1, K_COMMA};
            CH_EQUAL:   r = {1'b1, K_EQUAL};
            CH_PIPE:    r = {1'b1, K_PIPE};
            default:    r = {1'b0, K_PLUS};
        endcase
        return r;
    endfunction

    // Low field bits of an offset, zero-extended where the offset is narrower
    function automatic logic [FIELD_W-1:0] to_field(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+FIELD_W-1:0] ext;
        ext = {{FIELD_W{1'b0}}, v};
        return ext[FIELD_W-1:0];
    endfunction

endpackage

// ===== rtl/expression_token_lexer_top.sv =====
// Expression token lexer: one source item accepted per cycle while the queue has room.
// An item's tokens pass through the four-entry queue into the output register, which
// drains one token per cycle while pop is held; the queue absorbs an item that yields two
// tokens. Items are taken one per cycle while the queue has room.
// Reset (rst_n, asynchronous): queue and output empty, lexer idle, offset zero.
// Depends on etl_pkg, etl_front, etl_queue and etl_back.

module expression_token_lexer_top
    import etl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               mode,
    input  logic [7:0]         char_code,
    output logic               empty,
    input  logic               pop,
    output logic [KIND_W-1:0]  token_kind,
    output logic [FIELD_W-1:0] token_start,
    output logic [FIELD_W-1:0] token_length,
    output logic               last_of_run
);

    logic   accept;
    logic   entry_valid;
    entry_t entry;
    entry_t q_entry;
    logic   q_valid;
    logic   q_take;
    token_t out_tok;

    assign accept = push && !full;

    etl_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (mode),
        .char_code   (char_code),
        .entry_valid (entry_valid),
        .entry       (entry)
    );

    etl_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (entry_valid),
        .wr_entry  (entry),
        .full      (full),
        .rd_en     (q_take),
        .rd_entry  (q_entry),
        .not_empty (q_valid)
    );

    etl_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_take  (q_take),
        .pop     (pop),
        .empty   (empty),
        .out_tok (out_tok)
    );

    assign token_kind   = out_tok.kind;
    assign token_start  = out_tok.start;
    assign token_length = out_tok.length;
    assign last_of_run  = out_tok.last;

endmodule

// ===== rtl/etl_front.sv =====
// Front end of the expression token lexer: accepts items, classifies characters,
// tracks lexer state and offsets, and emits one queue entry per token-producing item.
// Depends on etl_pkg.

module etl_front
    import etl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                mode,
    input  logic [7:0]          char_code,
    output logic                entry_valid,
    output entry_t              entry
);

    logic [2:0]             state_reg, state_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;

    logic             flush_valid;
    logic [KIND_W-1:0] flush_kind;
    logic             flush_dot;
    logic             cont;
    logic             new_valid;
    logic [KIND_W-1:0] new_kind;
    logic [FIELD_W-1:0] new_len;
    logic [KIND_W:0]  single;
    logic [OFFSET_BITS-1:0] pend_len;
    token_t           flush_tok, new_tok;

    assign single   = single_kind(char_code);
    assign pend_len = pos_reg - start_reg;

    // Classify the item against the pending token
    always_comb
    begin
        state_next  = state_reg;
        start_next  = start_reg;
        pos_next    = (pos_reg != OFS_MAX) ? pos_reg + 1'b1 : pos_reg;
        flush_valid = 1'b0;
        flush_kind  = K_IDENT;
        flush_dot   = 1'b0;
        cont        = 1'b0;
        new_valid   = 1'b0;
        new_kind    = K_EOF;
        new_len     = '0;

        case (state_reg)
            ST_IDENT:
            begin
                flush_kind = K_IDENT;
                if (is_alpha(char_code) || is_digit(char_code) || char_code == CH_UNDER)
                    cont = 1'b1;
                else
                    flush_valid = 1'b1;
            end
            ST_INT:
            begin
                flush_kind = K_NUMBER;
                if (is_digit(char_code))
                    cont = 1'b1;
                else if (char_code == CH_POINT)
                begin
                    cont       = 1'b1;
                    state_next = ST_FRAC;
                end
                else
                    flush_valid = 1'b1;
            end
            ST_FRAC:
            begin
                flush_kind = K_NUMBER;
                if (is_digit(char_code))
                    cont = 1'b1;
                else
                    flush_valid = 1'b1;
            end
            ST_DOTP:
            begin
                flush_kind = K_DOT;
                flush_dot  = 1'b1;
                if (is_digit(char_code))
                begin
                    cont       = 1'b1;
                    state_next = ST_FRAC;
                end
                else
                    flush_valid = 1'b1;
            end
            default:
            begin
                flush_kind = K_IDENT;
            end
        endcase

        // Start a new token when the pending one did not continue
        if (!cont)
        begin
            state_next = ST_IDLE;
            if (single[KIND_W])
            begin
                new_valid = 1'b1;
                new_kind  = single[KIND_W-1:0];
                new_len   = {{(FIELD_W-1){1'b0}}, 1'b1};
            end
            else if (char_code == CH_POINT)
            begin
                state_next = ST_DOTP;
                start_next = pos_reg;
            end
            else if (is_digit(char_code))
            begin
                state_next = ST_INT;
                start_next = pos_reg;
            end
            else if (is_alpha(char_code))
            begin
                state_next = ST_IDENT;
                start_next = pos_reg;
            end
        end

        // End of source: flush anything pending, emit EOF, rewind
        if (mode)
        begin
            flush_valid = (state_reg != ST_IDLE);
            new_valid   = 1'b1;
            new_kind    = K_EOF;
            new_len     = '0;
            state_next  = ST_IDLE;
            start_next  = '0;
            pos_next    = '0;
        end
    end

    // Build the tokens of this item
    always_comb
    begin
        flush_tok.kind   = flush_kind;
        flush_tok.start  = to_field(start_reg);
        flush_tok.length = flush_dot ? {{(FIELD_W-1){1'b0}}, 1'b1} : to_field(pend_len);
        flush_tok.last   = !new_valid;

        new_tok.kind     = new_kind;
        new_tok.start    = to_field(pos_reg);
        new_tok.length   = new_len;
        new_tok.last     = 1'b1;

        entry.two   = flush_valid && new_valid;
        entry.tok0  = flush_valid ? flush_tok : new_tok;
        entry.tok1  = new_tok;
        entry_valid = accept && (flush_valid || new_valid);
    end

    // Advance lexer state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            start_reg <= '0;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

// ===== rtl/etl_queue.sv =====
// Short entry queue between the lexer front and the token output stage.
// Depends on etl_pkg.

module etl_queue
    import etl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  entry_t wr_entry,
    output logic   full,
    input  logic   rd_en,
    output entry_t rd_entry,
    output logic   not_empty
);

    entry_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_wr, do_rd;

    assign full      = (cnt_reg == QCNT_W'(QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_entry  = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

// ===== rtl/etl_back.sv =====
// Back end of the expression token lexer: takes queue entries and hands out
// their tokens one at a time from an output register. Depends on etl_pkg.

module etl_back
    import etl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   q_valid,
    input  entry_t q_entry,
    output logic   q_take,
    input  logic   pop,
    output logic   empty,
    output token_t out_tok
);

    logic   out_valid_reg, out_valid_next;
    logic   pend_reg, pend_next;
    token_t out_reg, out_next;
    token_t second_reg, second_next;
    logic   popped;
    logic   free;

    assign popped = pop && out_valid_reg;
    assign free   = !out_valid_reg || (popped && !pend_reg);
    assign q_take = free && q_valid;
    assign empty  = !out_valid_reg;
    assign out_tok = out_reg;

    // Load a new entry, or advance to the held second token
    always_comb
    begin
        out_valid_next = out_valid_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        second_next    = second_reg;
        if (popped && pend_reg)
        begin
            out_next  = second_reg;
            pend_next = 1'b0;
        end
        else if (free)
        begin
            out_valid_next = q_valid;
            if (q_valid)
            begin
                out_next    = q_entry.tok0;
                second_next = q_entry.tok1;
                pend_next   = q_entry.two;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    // Hold token payloads
    always_ff @(posedge clk)
    begin
        out_reg    <= out_next;
        second_reg <= second_next;
    end

endmodule
